// ===== hw/rtl/two_button_chord_tap_hold_defines.svh =====
// ----------------------------------------------------------------------------
// two_button_chord_tap_hold_defines
// assertion macros shared by the chord tap/hold block, empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef TWO_BUTTON_CHORD_TAP_HOLD_DEFINES_SVH
`define TWO_BUTTON_CHORD_TAP_HOLD_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define TBCTH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbcth assertion failed");

// next-cycle implication, checked out of reset
`define TBCTH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbcth assertion failed");

`else

`define TBCTH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TBCTH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/tbcth_pkg.sv =====
// ----------------------------------------------------------------------------
// tbcth_pkg
// types, register indexes and reset values of the chord tap/hold block
// ----------------------------------------------------------------------------
package tbcth_pkg;

    // payload widths fixed by the channel definitions
    localparam int NOW_W    = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam int TIME_WIDTH_DEFAULT = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUICK_TAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd2;

    // register reset values in ms
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET  = 16'd10;
    localparam logic [CFG_W-1:0] QUICK_TAP_RESET = 16'd200;
    localparam logic [CFG_W-1:0] HOLD_RESET      = 16'd250;

    typedef enum logic [1:0] {
        MODE_MOUSE  = 2'd0,
        MODE_SCROLL = 2'd1,
        MODE_MIDDLE = 2'd2
    } mode_t;

endpackage

// ===== hw/rtl/tbcth_ifs.sv =====
// ----------------------------------------------------------------------------
// tbcth_ifs
// valid/ready channels of the chord tap/hold block: samples, results, config
// ----------------------------------------------------------------------------
interface tbcth_sample_if;
    logic                        valid;
    logic                        ready;
    logic                        raw_left;
    logic                        raw_right;
    logic [tbcth_pkg::NOW_W-1:0] now_ms;

    modport source (output valid, raw_left, raw_right, now_ms, input ready);
    modport sink   (input valid, raw_left, raw_right, now_ms, output ready);
endinterface

interface tbcth_result_if;
    logic              valid;
    logic              ready;
    tbcth_pkg::mode_t  mode;
    logic              left_down;
    logic              middle_down;
    logic              right_click;

    modport source (output valid, mode, left_down, middle_down, right_click, input ready);
    modport sink   (input valid, mode, left_down, middle_down, right_click, output ready);
endinterface

interface tbcth_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tbcth_pkg::CFG_IDX_W-1:0] index;
    logic [tbcth_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/two_button_chord_tap_hold.sv =====
// ----------------------------------------------------------------------------
// two_button_chord_tap_hold
// debounced two-button pointer control with chord middle and right tap/hold
// ----------------------------------------------------------------------------
// One sample transfer (raw left/right levels and a millisecond timestamp)
// gives exactly one result transfer. Both buttons are debounced against
// debounce_time; both stable-pressed gives middle mode with the middle
// button held and left suppressed. Otherwise a right release no later than
// quick_tap_time after its press, and before scroll was decided, pulses
// right_click for one result; a right press reaching hold_time switches to
// scroll mode until release. Timestamps wrap modulo 2^TIME_WIDTH. The block
// takes one sample per clock while the result register is empty or being
// drained in the same cycle; the whole update sits between the sample port
// and the result register, set by three subtract-and-compare paths on
// TIME_WIDTH bits. Registers are written through cfg (always ready); the
// user must write them while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
`include "two_button_chord_tap_hold_defines.svh"

module two_button_chord_tap_hold #(
    parameter int TIME_WIDTH = tbcth_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    tbcth_sample_if.sink   sample,
    tbcth_result_if.source result,
    tbcth_cfg_if.sink      cfg
);

    typedef logic [TIME_WIDTH-1:0] time_t;

    // configuration registers
    logic [tbcth_pkg::CFG_W-1:0] debounce_reg;
    logic [tbcth_pkg::CFG_W-1:0] quick_tap_reg;
    logic [tbcth_pkg::CFG_W-1:0] hold_reg;

    // debounce state
    logic  left_seen_reg,  left_seen_next;
    logic  left_stable_reg, left_stable_next;
    time_t left_change_reg, left_change_next;
    logic  right_seen_reg,  right_seen_next;
    logic  right_stable_reg, right_stable_next;
    time_t right_change_reg, right_change_next;

    // tap/hold state
    logic  right_held_reg,    right_held_next;
    logic  right_decided_reg, right_decided_next;
    time_t right_press_reg,   right_press_next;
    logic  chord_reg,         chord_next;
    tbcth_pkg::mode_t mode_reg, mode_next;

    // result register
    logic res_valid_reg, res_valid_next;
    logic left_down_reg, left_down_next;
    logic click_reg,     click_next;

    logic  accept;
    time_t now_time;
    time_t left_elapsed;
    time_t right_elapsed;
    time_t press_elapsed;
    time_t debounce_t;
    time_t quick_tap_t;
    time_t hold_t;
    logic  press_start;
    logic  press_end;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    // output register drains or is empty: take the next sample
    assign sample.ready = !res_valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;

    assign result.valid       = res_valid_reg;
    assign result.mode        = mode_reg;
    assign result.left_down   = left_down_reg;
    assign result.middle_down = chord_reg;
    assign result.right_click = click_reg;

    // timestamp and thresholds at the internal time width
    assign now_time    = time_t'(sample.now_ms);
    assign debounce_t  = time_t'(debounce_reg);
    assign quick_tap_t = time_t'(quick_tap_reg);
    assign hold_t      = time_t'(hold_reg);

    // ------------------------------------------------------------------
    // single-pass update of one sample
    // ------------------------------------------------------------------
    always_comb
    begin
        // debounce: a level change restarts its timer, so elapsed is zero
        left_seen_next   = sample.raw_left;
        left_change_next = (sample.raw_left != left_seen_reg) ? now_time : left_change_reg;
        left_elapsed     = (sample.raw_left != left_seen_reg) ? '0
                                                             : now_time - left_change_reg;
        left_stable_next = (left_elapsed >= debounce_t) ? sample.raw_left : left_stable_reg;

        right_seen_next   = sample.raw_right;
        right_change_next = (sample.raw_right != right_seen_reg) ? now_time : right_change_reg;
        right_elapsed     = (sample.raw_right != right_seen_reg) ? '0
                                                                : now_time - right_change_reg;
        right_stable_next = (right_elapsed >= debounce_t) ? sample.raw_right
                                                          : right_stable_reg;

        // tap/hold edges of the debounced right level
        press_start   = right_stable_next && !right_held_reg;
        press_end     = !right_stable_next && right_held_reg;
        // a fresh press is timed from this very sample
        press_elapsed = press_start ? '0 : now_time - right_press_reg;

        right_held_next    = right_held_reg;
        right_decided_next = right_decided_reg;
        right_press_next   = right_press_reg;
        mode_next          = mode_reg;
        chord_next         = 1'b0;
        left_down_next     = 1'b0;
        click_next         = 1'b0;

        if (left_stable_next && right_stable_next)
        begin
            // chord: right tracking frozen, middle held
            mode_next  = tbcth_pkg::MODE_MIDDLE;
            chord_next = 1'b1;
        end
        else
        begin
            if (press_start)
            begin
                right_held_next    = 1'b1;
                right_decided_next = 1'b0;
                right_press_next   = now_time;
            end
            else if (press_end)
            begin
                // quick release before scroll was decided clicks
                click_next         = !right_decided_reg && (press_elapsed <= quick_tap_t);
                right_held_next    = 1'b0;
                right_decided_next = 1'b0;
            end

            if (right_held_next && !right_decided_next && (press_elapsed >= hold_t))
            begin
                mode_next          = tbcth_pkg::MODE_SCROLL;
                right_decided_next = 1'b1;
            end

            left_down_next = left_stable_next;

            // idle right button: back to mouse, else mode is kept
            if (!right_held_next)
            begin
                mode_next = tbcth_pkg::MODE_MOUSE;
            end
        end

        // result register occupancy
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= tbcth_pkg::DEBOUNCE_RESET;
            quick_tap_reg <= tbcth_pkg::QUICK_TAP_RESET;
            hold_reg      <= tbcth_pkg::HOLD_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            // writes beyond the register list are dropped
            unique case (cfg.index)
                tbcth_pkg::CFG_DEBOUNCE:  debounce_reg  <= cfg.data;
                tbcth_pkg::CFG_QUICK_TAP: quick_tap_reg <= cfg.data;
                tbcth_pkg::CFG_HOLD:      hold_reg      <= cfg.data;
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // state and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_seen_reg     <= 1'b0;
            left_stable_reg   <= 1'b0;
            left_change_reg   <= '0;
            right_seen_reg    <= 1'b0;
            right_stable_reg  <= 1'b0;
            right_change_reg  <= '0;
            right_held_reg    <= 1'b0;
            right_decided_reg <= 1'b0;
            right_press_reg   <= '0;
            chord_reg         <= 1'b0;
            mode_reg          <= tbcth_pkg::MODE_MOUSE;
            res_valid_reg     <= 1'b0;
            left_down_reg     <= 1'b0;
            click_reg         <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                left_seen_reg     <= left_seen_next;
                left_stable_reg   <= left_stable_next;
                left_change_reg   <= left_change_next;
                right_seen_reg    <= right_seen_next;
                right_stable_reg  <= right_stable_next;
                right_change_reg  <= right_change_next;
                right_held_reg    <= right_held_next;
                right_decided_reg <= right_decided_next;
                right_press_reg   <= right_press_next;
                chord_reg         <= chord_next;
                mode_reg          <= mode_next;
                left_down_reg     <= left_down_next;
                click_reg         <= click_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // chord result: middle mode and left suppressed
    `TBCTH_ASSERT_IMPL(a_chord_result, clk, rst_n, res_valid_reg && chord_reg,
        (mode_reg == tbcth_pkg::MODE_MIDDLE) && !left_down_reg)
    // a click ends the right press, so the mode is back to mouse
    `TBCTH_ASSERT_IMPL(a_click_mouse, clk, rst_n, res_valid_reg && click_reg,
        (mode_reg == tbcth_pkg::MODE_MOUSE) && !chord_reg && !right_held_reg)
    // scroll decision only exists inside a held right press
    `TBCTH_ASSERT_IMPL(a_decided_held, clk, rst_n, right_decided_reg, right_held_reg)
    // chord flag only with both debounced levels pressed
    `TBCTH_ASSERT_IMPL(a_chord_stable, clk, rst_n, chord_reg,
        left_stable_reg && right_stable_reg)
    // an accepted sample always leaves a result waiting
    `TBCTH_ASSERT_NEXT(a_accept_result, clk, rst_n, accept, res_valid_reg)

endmodule
